// ----- design/cpbc_pkg.sv -----
// shared types and constants for the cascaded pid balance controller
package cpbc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_REGS       = 6;
  localparam int REG_ADDR_W     = 3;

  // configuration register indexes
  localparam logic [REG_ADDR_W-1:0] REG_ANGLE_KP = 3'd0;
  localparam logic [REG_ADDR_W-1:0] REG_ANGLE_KI = 3'd1;
  localparam logic [REG_ADDR_W-1:0] REG_ANGLE_KD = 3'd2;
  localparam logic [REG_ADDR_W-1:0] REG_RATE_KP  = 3'd3;
  localparam logic [REG_ADDR_W-1:0] REG_RATE_KI  = 3'd4;
  localparam logic [REG_ADDR_W-1:0] REG_RATE_KD  = 3'd5;

  // pid term selection
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // loop selection
  localparam logic LOOP_ANGLE = 1'b0;
  localparam logic LOOP_RATE  = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ERR  = 6'b000010,
    S_MLO  = 6'b000100,
    S_MHI  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic       cap;
    logic       err;
    logic       mlo;
    logic       mhi;
    logic       fin;
    logic       acc_en;
    logic       loop_sel;
    logic [1:0] term;
    logic       load_out;
    logic       cut;
  } cmd_t;

  typedef struct packed {
    logic tilt;
  } stat_t;

endpackage

// ----- design/cpbc_ctrl.sv -----
// sequencer for the cascaded pid balance controller
module cpbc_ctrl
  import cpbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  logic  out_tready,
  output logic  out_tvalid,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic       loop_r, loop_nxt;
  logic [1:0] term_r, term_nxt;
  logic       cut_r, cut_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       slot_free;

  assign slot_free  = !ovalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt    = state_r;
    loop_nxt     = loop_r;
    term_nxt     = term_r;
    cut_nxt      = cut_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    cmd          = '0;
    cmd.loop_sel = loop_r;
    cmd.term     = term_r;
    cmd.cut      = cut_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          loop_nxt  = LOOP_ANGLE;
          cut_nxt   = 1'b0;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err  = 1'b1;
        term_nxt = TERM_P;
        if (loop_r == LOOP_ANGLE && stat.tilt) begin
          cut_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MLO;
        end
      end
      S_MLO: begin
        cmd.mlo    = 1'b1;
        cmd.acc_en = (term_r != TERM_P);
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mhi = 1'b1;
        if (term_r == TERM_D) begin
          state_nxt = S_FIN;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = S_MLO;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (loop_r == LOOP_ANGLE) begin
          loop_nxt  = LOOP_RATE;
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      loop_r   <= LOOP_ANGLE;
      term_r   <= TERM_P;
      cut_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loop_r   <= loop_nxt;
      term_r   <= term_nxt;
      cut_r    <= cut_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_ERR)
    else $error("accepted transfer did not start the angle loop");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!ovalid_r || out_tready))
    else $error("result register overwritten while held");

  a_fin_last_term: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> term_r == TERM_D && $past(state_r) == S_MHI)
    else $error("loop finished before all three terms");

  a_cut_angle_only: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && cut_r |-> $past(state_r) == S_ERR || $past(state_r) == S_OUT)
    else $error("tilt cutoff raised outside the angle error step");

endmodule

// ----- design/cpbc_dp.sv -----
// arithmetic datapath: gains, pid state, shared multiplier and accumulator
module cpbc_dp
  import cpbc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  cfg_wr_en,
  input  logic [REG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_WIDTH-1:0] cfg_wdata,
  input  logic [DATA_WIDTH-1:0] angle_in,
  input  logic [DATA_WIDTH-1:0] rate_in,
  input  logic [DATA_WIDTH-1:0] steer_in,
  output logic [DATA_WIDTH-1:0] left_out,
  output logic [DATA_WIDTH-1:0] right_out,
  output logic                  cut_out
);

  localparam int W  = DATA_WIDTH;
  localparam int H  = (W + 1) / 2;
  localparam int IW = (W + 2 > FRAC_BITS + 12) ? W + 2 : FRAC_BITS + 12;

  localparam logic signed [W+1:0] MAX_X = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] MIN_X = {3'b111, {(W-1){1'b0}}};
  localparam logic signed [IW-1:0] ILIM  = IW'(1000) <<< FRAC_BITS;
  localparam logic signed [IW-1:0] NILIM = -ILIM;
  localparam logic signed [IW-1:0] TLIM  = IW'(20) <<< FRAC_BITS;
  localparam logic signed [IW-1:0] NTLIM = -TLIM;

  function automatic logic [W-1:0] sat_w(input logic signed [W+1:0] x);
    if (x > MAX_X) sat_w = MAX_X[W-1:0];
    else if (x < MIN_X) sat_w = MIN_X[W-1:0];
    else sat_w = x[W-1:0];
  endfunction

  function automatic logic signed [W+1:0] ext(input logic [W-1:0] v);
    ext = {{2{v[W-1]}}, v};
  endfunction

  // scale full product by frac bits toward zero, saturate, apply sign
  function automatic logic signed [W+1:0] qscale(input logic [2*W-1:0] p, input logic n);
    logic [2*W-1:0] sh;
    logic [W-1:0]   lim;
    logic [W-1:0]   mg;
    sh  = p >> FRAC_BITS;
    lim = n ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    if ((|sh[2*W-1:W]) || (sh[W-1:0] > lim)) mg = lim;
    else mg = sh[W-1:0];
    qscale = n ? -$signed({2'b00, mg}) : $signed({2'b00, mg});
  endfunction

  logic [W-1:0] gains_r [NUM_REGS];
  logic [W-1:0] angle_r, rate_r, steer_r;
  logic         tilt_r;
  logic [W-1:0] angle_last_r, angle_integ_r, rate_last_r, rate_integ_r;
  logic [W-1:0] e_r, d_r, s_r, pid_out_r;
  logic [W+H-1:0] plo_r;
  logic [2*W-1:0] prod_r;
  logic           neg_r;
  logic signed [W+1:0] acc_r;
  logic [W-1:0] left_r, right_r;
  logic         cut_r;

  // error step
  logic [W-1:0] sp, meas, last, integ, e_v, d_v, s_sat, s_v;
  logic signed [IW-1:0] s_ext, a_ext;
  logic tilt_v;

  always_comb begin
    sp    = (cmd.loop_sel == LOOP_RATE) ? pid_out_r : '0;
    meas  = (cmd.loop_sel == LOOP_RATE) ? rate_r : angle_r;
    last  = (cmd.loop_sel == LOOP_RATE) ? rate_last_r : angle_last_r;
    integ = (cmd.loop_sel == LOOP_RATE) ? rate_integ_r : angle_integ_r;
    e_v   = sat_w(ext(sp) - ext(meas));
    d_v   = sat_w(ext(e_v) - ext(last));
    s_sat = sat_w(ext(integ) + ext(e_v));
    s_ext = IW'($signed(s_sat));
    if (s_ext > ILIM) s_v = ILIM[W-1:0];
    else if (s_ext < NILIM) s_v = NILIM[W-1:0];
    else s_v = s_sat;
    a_ext  = IW'($signed(angle_in));
    tilt_v = (a_ext > TLIM) || (a_ext < NTLIM);
  end

  // operand selection and shared multiplier
  logic [REG_ADDR_W-1:0] gidx;
  logic [W-1:0] op_a, op_b, ma, mb;
  logic [H-1:0] mpart;
  logic [W+H-1:0] mprod;
  logic neg_v;
  logic signed [W+1:0] t_v, fin_sum;

  always_comb begin
    gidx = (cmd.loop_sel == LOOP_RATE) ? REG_RATE_KP + REG_ADDR_W'(cmd.term)
                                       : REG_ANGLE_KP + REG_ADDR_W'(cmd.term);
    case (cmd.term)
      TERM_P:  op_a = e_r;
      TERM_I:  op_a = s_r;
      TERM_D:  op_a = d_r;
      default: op_a = d_r;
    endcase
    op_b  = gains_r[gidx];
    ma    = op_a[W-1] ? (~op_a + 1'b1) : op_a;
    mb    = op_b[W-1] ? (~op_b + 1'b1) : op_b;
    neg_v = op_a[W-1] ^ op_b[W-1];
    mpart = cmd.mhi ? H'(mb[W-1:H]) : mb[H-1:0];
    mprod = (W+H)'(ma) * (W+H)'(mpart);
    t_v     = qscale(prod_r, neg_r);
    fin_sum = acc_r + t_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) gains_r[i] <= '0;
      angle_last_r  <= '0;
      angle_integ_r <= '0;
      rate_last_r   <= '0;
      rate_integ_r  <= '0;
    end else begin
      if (cfg_wr_en && (cfg_addr <= REG_RATE_KD)) gains_r[cfg_addr] <= cfg_wdata;
      if (cmd.err && !(cmd.loop_sel == LOOP_ANGLE && tilt_r)) begin
        if (cmd.loop_sel == LOOP_RATE) begin
          rate_last_r  <= e_v;
          rate_integ_r <= s_v;
        end else begin
          angle_last_r  <= e_v;
          angle_integ_r <= s_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      angle_r <= angle_in;
      rate_r  <= rate_in;
      steer_r <= steer_in;
      tilt_r  <= tilt_v;
    end
    if (cmd.err) begin
      e_r   <= e_v;
      d_r   <= d_v;
      s_r   <= s_v;
      acc_r <= '0;
    end
    if (cmd.mlo) begin
      plo_r <= mprod;
      neg_r <= neg_v;
      if (cmd.acc_en) acc_r <= fin_sum;
    end
    if (cmd.mhi) begin
      prod_r <= {{(W-H){1'b0}}, plo_r} + ({{(W-H){1'b0}}, mprod} << H);
    end
    if (cmd.fin) pid_out_r <= sat_w(fin_sum);
    if (cmd.load_out) begin
      cut_r <= cmd.cut;
      if (cmd.cut) begin
        left_r  <= '0;
        right_r <= '0;
      end else begin
        left_r  <= sat_w(ext(steer_r) + ext(pid_out_r));
        right_r <= sat_w(ext(pid_out_r) - ext(steer_r));
      end
    end
  end

  assign stat.tilt = tilt_r;
  assign left_out  = left_r;
  assign right_out = right_r;
  assign cut_out   = cut_r;

endmodule

// ----- design/cascaded_pid_balance_controller.sv -----
// top level of the cascaded pid balance controller
//
//  channel | direction | handshake             | payload
//  in_     | slave     | in_tvalid / in_tready  | in_tdata: pitch_angle, pitch_rate, steer_target
//  out_    | master    | out_tvalid / out_tready| out_tdata: left_drive, right_drive; out_tuser: tilt
//  cfg_    | write     | cfg_wr_en              | cfg_addr, cfg_wdata (six gain registers)
//
// one sample at a time: the result is registered once the output register is free, and
// then the block is ready for the next input transfer; the angle loop and then the rate
// loop each run an error step, three products in a low and a high half step, and a finish,
// then the output load follows; the single multiplier takes one half of a gain magnitude
// per cycle; a tilt cutoff sample goes from the angle error step straight to the output load
// a new sample is taken while the previous result still waits on out_tready
// rst_n is synchronous, active low; it clears gains, pid state and the valid flag
module cascaded_pid_balance_controller
  import cpbc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pitch_angle, pitch_rate, steer_target from bit 0 up, zero padded
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]  in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // left_drive, right_drive from bit 0 up, zero padded
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]  out_tdata,
  // tilt_cutoff
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [REG_ADDR_W-1:0]               cfg_addr,
  input  logic [DATA_WIDTH-1:0]               cfg_wdata
);

  localparam int W      = DATA_WIDTH;
  localparam int OUT_TW = ((2*DATA_WIDTH+7)/8)*8;

  cmd_t  cmd;
  stat_t stat;
  logic [W-1:0] left_w, right_w;

  // sequencer: handshakes and step order
  cpbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  // arithmetic, gains and loop state
  cpbc_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .angle_in  (in_tdata[W-1:0]),
    .rate_in   (in_tdata[2*W-1:W]),
    .steer_in  (in_tdata[3*W-1:2*W]),
    .left_out  (left_w),
    .right_out (right_w),
    .cut_out   (out_tuser)
  );

  assign out_tdata = OUT_TW'({right_w, left_w});

endmodule

// ----- verif/cascaded_pid_balance_controller_test.sv -----
// self-checking testbench for the cascaded pid balance controller
`timescale 1ns / 100ps

class drive_scoreboard;
  localparam int     FRAC       = cpbc_pkg::FRAC_BITS_DEF;
  localparam longint WMAX       = 64'sd2147483647;
  localparam longint WMIN       = -64'sd2147483648;
  localparam longint TILT_LIM   = longint'(20) <<< FRAC;
  localparam longint ACC_LIM    = longint'(1000) <<< FRAC;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
    logic        tilt;
  } drive_t;

  drive_t expected_drives[$];
  longint gain[cpbc_pkg::NUM_REGS];
  longint ang_prev_err, ang_accum, rt_prev_err, rt_accum;
  int     fault_count;
  int     checked;

  function longint clip(longint x);
    if (x > WMAX) return WMAX;
    if (x < WMIN) return WMIN;
    return x;
  endfunction

  // exact product, scaled down toward zero, saturated
  function longint scaled_product(longint a, longint b);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = m >> FRAC;
    return clip((p < 0) ? -m : m);
  endfunction

  function longint pid_update(input longint target, input longint meas,
                              inout longint prev_err, inout longint accum,
                              input longint kp, input longint ki, input longint kd);
    longint err, diff, sum;
    err  = clip(target - meas);
    diff = clip(err - prev_err);
    sum  = clip(accum + err);
    if (sum > ACC_LIM) sum = ACC_LIM;
    if (sum < -ACC_LIM) sum = -ACC_LIM;
    prev_err = err;
    accum    = sum;
    return clip(scaled_product(err, kp) + scaled_product(sum, ki) +
                scaled_product(diff, kd));
  endfunction

  function void load_gain(logic [cpbc_pkg::REG_ADDR_W-1:0] idx, logic [31:0] val);
    if (idx < cpbc_pkg::NUM_REGS) gain[idx] = longint'($signed(val));
  endfunction

  function int pending();
    return expected_drives.size();
  endfunction

  function void note_sample(logic [31:0] angle, logic [31:0] rate, logic [31:0] steer);
    drive_t want;
    longint a, r, s, a_out, r_out;
    a = longint'($signed(angle));
    r = longint'($signed(rate));
    s = longint'($signed(steer));
    if (a > TILT_LIM || a < -TILT_LIM) begin
      want.left  = '0;
      want.right = '0;
      want.tilt  = 1'b1;
    end else begin
      a_out = pid_update(0, a, ang_prev_err, ang_accum, gain[cpbc_pkg::REG_ANGLE_KP],
                         gain[cpbc_pkg::REG_ANGLE_KI], gain[cpbc_pkg::REG_ANGLE_KD]);
      r_out = pid_update(a_out, r, rt_prev_err, rt_accum, gain[cpbc_pkg::REG_RATE_KP],
                         gain[cpbc_pkg::REG_RATE_KI], gain[cpbc_pkg::REG_RATE_KD]);
      want.left  = 32'(clip(s + r_out));
      want.right = 32'(clip(r_out - s));
      want.tilt  = 1'b0;
    end
    expected_drives.push_back(want);
  endfunction

  function void flag(string field, logic [31:0] want, logic [31:0] got);
    fault_count++;
    $error("%s: expected %0d, actual %0d", field, $signed(want), $signed(got));
  endfunction

  function void check_drive(logic [31:0] left, logic [31:0] right, logic tilt);
    drive_t want;
    if (expected_drives.size() == 0) begin
      fault_count++;
      $error("drive transfer with no sample pending: left %0d, right %0d",
             $signed(left), $signed(right));
      return;
    end
    want = expected_drives.pop_front();
    checked++;
    if (left !== want.left) flag("left_drive", want.left, left);
    if (right !== want.right) flag("right_drive", want.right, right);
    if (tilt !== want.tilt) flag("tilt_cutoff", {31'd0, want.tilt}, {31'd0, tilt});
  endfunction
endclass

module cascaded_pid_balance_controller_test;
  import cpbc_pkg::*;

  localparam int     DW           = DATA_WIDTH_DEF;
  localparam int     CLK_HALF     = 5;
  localparam int     RESET_CYCLES = 7;
  // idle margin left after the last result is checked
  localparam int     TAIL_CYCLES  = 24;
  // long receiver stall, started once after this many results
  localparam int     HOLD_CYCLES  = 400;
  localparam int     HOLD_AFTER   = 600;
  localparam longint CYCLE_LIMIT  = 1000000;

  // register slots past the last gain, writes there must be ignored
  localparam logic [REG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  // q16.16 values used by the directed part
  localparam logic [DW-1:0] Q_MAX     = 32'h7fff_ffff;
  localparam logic [DW-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [DW-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DW-1:0] TILT_EDGE = 32'h0014_0000;  // 20.0 degrees
  localparam longint        TILT_SPAN = 1310720;        // 20.0 as an integer
  localparam longint        RATE_SPAN = 6553600;        // 100.0
  localparam longint        WIDE_SPAN = 65536000;       // 1000.0, integral clamp

  logic            clk = 1'b0;
  logic            rst_n;
  logic [3*DW-1:0] in_tdata;
  logic            in_tvalid;
  logic            in_tready;
  logic [2*DW-1:0] out_tdata;
  logic            out_tuser;
  logic            out_tvalid;
  logic            out_tready;
  logic            cfg_wr_en;
  logic [REG_ADDR_W-1:0] cfg_addr;
  logic [DW-1:0]   cfg_wdata;

  drive_scoreboard sb = new;
  longint          cycle_count = 0;
  bit              in_steady = 1'b0;   // sender runs without gaps while set
  bit              out_steady = 1'b0;  // receiver adds no random stalls while set
  int              lean = 0;           // sign of the current pitch lean, 0 for none

  cascaded_pid_balance_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cascaded_pid_balance_controller_test: FAIL");
      $finish;
    end
  end

  // every accepted sample gets its prediction, every drive transfer is checked
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_sample(in_tdata[DW-1:0], in_tdata[2*DW-1:DW], in_tdata[3*DW-1:2*DW]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_drive(out_tdata[DW-1:0], out_tdata[2*DW-1:DW], out_tuser);
  end

  // random gap per transfer, with gap-free stretches toggled now and then
  function automatic int draw_gap(inout bit steady);
    if ($urandom_range(0, 29) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [DW-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // mostly inside the tilt window so the loops run; leaning stretches push the
  // angle integral into its clamp
  function automatic logic [DW-1:0] pick_angle();
    if ($urandom_range(0, 79) == 0) lean = int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (lean == 0) return DW'(spread(TILT_SPAN));
        return DW'(lean * longint'($urandom_range(0, TILT_SPAN)));
      end
      6: begin
        case ($urandom_range(0, 3))
          0:       return TILT_EDGE;
          1:       return -TILT_EDGE;
          2:       return TILT_EDGE + 1;
          default: return -(TILT_EDGE + 1);
        endcase
      end
      7:       return $urandom;
      8:       return DW'(spread(256));
      default: return pick_extreme();
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_wide();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DW'(spread(RATE_SPAN));
      4, 5:       return DW'(spread(WIDE_SPAN));
      6, 7:       return $urandom;
      8:          return pick_extreme();
      default:    return DW'(spread(16));
    endcase
  endfunction

  // one sample transfer; returns at the edge where it was taken
  task automatic send_sample(input logic [DW-1:0] angle, rate, steer);
    int gap;
    gap = draw_gap(in_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {steer, rate, angle};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // gain writes, only while nothing is in flight; spare slots get noise when spare is set
  task automatic load_gains(input logic [DW-1:0] akp, aki, akd, rkp, rki, rkd,
                            input bit spare);
    logic [REG_ADDR_W-1:0] idx [8];
    logic [DW-1:0]         val [8];
    int                    n;
    idx = '{REG_ANGLE_KP, REG_ANGLE_KI, REG_ANGLE_KD, REG_RATE_KP, REG_RATE_KI,
            REG_RATE_KD, REG_SPARE_LO, REG_SPARE_HI};
    val = '{akp, aki, akd, rkp, rki, rkd, $urandom, $urandom};
    n = spare ? 8 : 6;
    for (int i = 0; i < n; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.load_gain(idx[i], val[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // random samples, then drain so the block is idle for the next gain set
  task automatic run_random(input int count);
    repeat (count) send_sample(pick_angle(), pick_wide(), pick_wide());
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off that backs the block up
  // until it stops taking samples
  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && sb.checked >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_gap(out_steady);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_ANGLE_KP;
    cfg_wdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gains still at reset, drives are just plus and minus the steering term outside a tilt cutoff
    run_random(40);

    // moderate gains: 2.0, 0.5, -1.25 / 1.5, -0.25, 3.0
    load_gains(32'h0002_0000, 32'h0000_8000, 32'hfffe_c000,
               32'h0001_8000, 32'hffff_c000, 32'h0003_0000, 1'b1);
    send_sample('0, '0, '0);
    // exactly at the tilt limit the loops still run
    send_sample(TILT_EDGE, '0, '0);
    send_sample(-TILT_EDGE, '0, '0);
    // one step past the limit, and the field extremes, cut the drives
    send_sample(TILT_EDGE + 1, Q_MAX, Q_MIN);
    send_sample(-(TILT_EDGE + 1), Q_MIN, Q_MAX);
    send_sample(Q_MAX, '0, Q_ONE);
    send_sample(Q_MIN, Q_ONE, '0);
    // rate and steering extremes saturate the error and the drives
    send_sample(32'd1, Q_MAX, Q_MAX);
    send_sample('1, Q_MIN, Q_MIN);
    send_sample('0, Q_MIN, Q_MAX);
    send_sample('0, Q_MAX, Q_MIN);
    send_sample('0, '0, Q_MAX);
    run_random(400);

    // largest gains, products of large errors overflow
    load_gains(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    send_sample(TILT_EDGE, Q_MIN, '0);
    send_sample(-TILT_EDGE, Q_MAX, '0);
    send_sample(TILT_EDGE, Q_MAX, Q_MAX);
    send_sample(-TILT_EDGE, Q_MIN, Q_MIN);
    send_sample('0, '0, '0);
    send_sample(32'd1, 32'd1, 32'd1);
    send_sample(TILT_EDGE + 1, '0, '0);
    send_sample('0, Q_MIN, Q_MAX);
    run_random(250);

    // most negative gains
    load_gains(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    run_random(250);

    // full range random gains
    repeat (2) begin
      load_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
      run_random(250);
    end

    // small random gains, within plus or minus 4.0
    load_gains(DW'(spread(262144)), DW'(spread(262144)), DW'(spread(262144)),
               DW'(spread(262144)), DW'(spread(262144)), DW'(spread(262144)), 1'b1);
    run_random(400);

    // strong angle loop feeding a saturating rate loop
    load_gains(32'h0100_0000, Q_ONE, Q_MIN, Q_MAX, 32'h0000_0100, -Q_ONE, 1'b0);
    run_random(250);

    if (sb.pending() != 0)
      $error("%0d expected drive results never arrived", sb.pending());
    if (sb.fault_count == 0 && sb.pending() == 0)
      $display("cascaded_pid_balance_controller_test: PASS");
    else
      $display("cascaded_pid_balance_controller_test: FAIL");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/cpbc_pkg.sv
design/cpbc_ctrl.sv
design/cpbc_dp.sv
design/cascaded_pid_balance_controller.sv
verif/cascaded_pid_balance_controller_test.sv
